// ----- sv/grid_cell_coulomb_potential_macros.svh -----
// ----------------------------------------------------------------------------
// grid_cell_coulomb_potential_macros
// Assertion macros shared by the grid cell potential design.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_COULOMB_POTENTIAL_MACROS_SVH
`define GRID_CELL_COULOMB_POTENTIAL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define GCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/gcp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared widths, limits, register indexes and command types.
// ----------------------------------------------------------------------------
package gcp_pkg;
	localparam int CoordW   = 24;
	localparam int ChargeW  = 24;
	localparam int RadiusW  = 14;
	localparam int BoxChgW  = 32;
	localparam int PotW     = 48;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;
	localparam int SqW      = 50;
	localparam int DistW    = 25;

	localparam int MinRadiusDef   = 1024;
	localparam int ClashOffsetDef = 1024;
	localparam int CoordFracDef   = 10;

	localparam logic [CfgIdxW-1:0] RegMinX  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegMinY  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegMinZ  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegMaxX  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMaxY  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegMaxZ  = 3'd5;
	localparam logic [CfgIdxW-1:0] RegProbe = 3'd6;
	localparam logic [CfgIdxW-1:0] RegMode  = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the atom and form distance terms
		logic sq_sum;    // sum the squared axis distances
		logic sqrt_init; // start the square root
		logic sqrt_step; // one root iteration
		logic div_init;  // start the division
		logic div_step;  // one division iteration
		logic finish;    // update the sums and the result register
	} gcp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic need_div;
	} gcp_sts_t;
endpackage

// ----- sv/gcp_stream_if.sv -----
// ----------------------------------------------------------------------------
// gcp_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface gcp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/gcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcp_ctrl
// Sequencer for one atom: load, square sum, root, divide when needed, accumulate.
// ----------------------------------------------------------------------------
`include "grid_cell_coulomb_potential_macros.svh"

module gcp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_busy,
	input  gcp_pkg::gcp_sts_t sts,
	output gcp_pkg::gcp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_SQI, S_SQRT, S_DIVI, S_DIV, S_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.sq_sum    = (state_q == S_SQ);
		cmd.sqrt_init = (state_q == S_SQI);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.div_init  = (state_q == S_DIVI);
		cmd.div_step  = (state_q == S_DIV);
		cmd.finish    = (state_q == S_FIN) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SQ;
				S_SQ:   state_q <= S_SQI;
				S_SQI:  state_q <= S_SQRT;
				S_SQRT: if (sts.sqrt_done) state_q <= sts.need_div ? S_DIVI : S_FIN;
				S_DIVI: state_q <= S_DIV;
				S_DIV:  if (sts.div_done) state_q <= S_FIN;
				S_FIN:  if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GCP_ASSERT_IMP(a_one_hot_cmd, clk, arst_n, 1'b1, $onehot0(cmd), "commands overlap")
	`GCP_ASSERT_NEXT(a_load_seq, clk, arst_n, cmd.load, cmd.sq_sum, "square sum must follow load")
	`GCP_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !cmd.div_step && !cmd.sqrt_step,
		"accepting while busy")
endmodule

// ----- sv/gcp_datapath.sv -----
// ----------------------------------------------------------------------------
// gcp_datapath
// Distance, iterative root and divider, saturating sums and result register.
// ----------------------------------------------------------------------------
`include "grid_cell_coulomb_potential_macros.svh"

module gcp_datapath #(
	parameter int MIN_RADIUS      = gcp_pkg::MinRadiusDef,
	parameter int CLASH_OFFSET    = gcp_pkg::ClashOffsetDef,
	parameter int COORD_FRAC_BITS = gcp_pkg::CoordFracDef
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gcp_pkg::gcp_cmd_t                    cmd,
	output gcp_pkg::gcp_sts_t                    sts,
	input  logic signed [gcp_pkg::CoordW-1:0]    min_x, min_y, min_z,
	input  logic signed [gcp_pkg::CoordW-1:0]    max_x, max_y, max_z,
	input  logic [gcp_pkg::RadiusW-1:0]          probe,
	input  logic                                 mode,
	input  logic signed [gcp_pkg::CoordW-1:0]    ax, ay, az,
	input  logic signed [gcp_pkg::ChargeW-1:0]   achg,
	input  logic                                 achg_known,
	input  logic [gcp_pkg::RadiusW-1:0]          arad,
	input  logic                                 arad_known,
	input  logic                                 alast,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gcp_pkg::BoxChgW-1:0]   out_chg,
	output logic signed [gcp_pkg::PotW-1:0]      out_pot,
	output logic                                 out_clash
);
	localparam int DW   = gcp_pkg::DistW;
	localparam int SQW  = gcp_pkg::SqW;
	localparam int NUMW = gcp_pkg::ChargeW + COORD_FRAC_BITS;
	localparam int DCW  = gcp_pkg::CoordW + 2;
	localparam int ADW  = gcp_pkg::CoordW + 1;
	localparam int SRW  = $clog2(SQW / 2 + 1);
	localparam int DVW  = $clog2(NUMW + 1);
	localparam int THW  = gcp_pkg::RadiusW + 2;
	localparam logic signed [gcp_pkg::BoxChgW-1:0] ChgMax = {1'b0, {(gcp_pkg::BoxChgW-1){1'b1}}};
	localparam logic signed [gcp_pkg::BoxChgW-1:0] ChgMin = {1'b1, {(gcp_pkg::BoxChgW-1){1'b0}}};
	localparam logic signed [gcp_pkg::PotW-1:0]    PotMax = {1'b0, {(gcp_pkg::PotW-1){1'b1}}};
	localparam logic signed [gcp_pkg::PotW-1:0]    PotMin = {1'b1, {(gcp_pkg::PotW-1){1'b0}}};

	// Per-atom registers.
	logic [ADW-1:0]                      dx_q, dy_q, dz_q;
	logic                                inside_q, last_q;
	logic signed [gcp_pkg::ChargeW-1:0]  chg_q;
	logic [THW-1:0]                      thr_q;
	logic [SQW-1:0]                      sq_q;
	// Root unit.
	logic [SQW-1:0]                      rem_q;
	logic [DW-1:0]                       root_q;
	logic [SRW-1:0]                      scnt_q;
	// Divider unit.
	logic [NUMW-1:0]                     quo_q;
	logic [DW:0]                         drem_q;
	logic [DVW-1:0]                      dcnt_q;
	logic                                neg_q;
	// Sums.
	logic signed [gcp_pkg::BoxChgW-1:0]  cacc_q;
	logic signed [gcp_pkg::PotW-1:0]     eacc_q;
	logic                                clash_q;

	function automatic logic [ADW-1:0] abs_dist(
		input logic signed [gcp_pkg::CoordW-1:0] lo,
		input logic signed [gcp_pkg::CoordW-1:0] hi,
		input logic signed [gcp_pkg::CoordW-1:0] p
	);
		logic signed [DCW-1:0] ext, c, d;
		begin
			ext = DCW'(hi) - DCW'(lo);
			c   = DCW'(lo) + (ext >>> 1);
			d   = c - DCW'(p);
			abs_dist = d[DCW-1] ? ADW'(-d) : ADW'(d);
		end
	endfunction

	logic in_x, in_y, in_z;
	assign in_x = (ax > min_x) && (ax <= max_x);
	assign in_y = (ay > min_y) && (ay <= max_y);
	assign in_z = (az > min_z) && (az <= max_z);

	// Root step: remainder against the trial 4*root+1.
	logic [SQW-1:0] pair;
	logic [SQW-1:0] trial;
	logic [SQW+1:0] shifted;
	assign pair    = sq_q >> (2 * (SQW / 2 - 1 - scnt_q));
	assign shifted = {rem_q, pair[1:0]};
	assign trial   = SQW'({root_q, 2'b01});

	// Divider step on the magnitude of the numerator.
	logic [DW:0] dshift;
	assign dshift = {drem_q[DW-1:0], quo_q[NUMW-1]};

	logic signed [gcp_pkg::PotW-1:0] term;
	assign term = neg_q ? -gcp_pkg::PotW'(quo_q) : gcp_pkg::PotW'(quo_q);

	logic signed [gcp_pkg::BoxChgW:0] csum;
	logic signed [gcp_pkg::PotW:0]    esum;
	assign csum = (gcp_pkg::BoxChgW+1)'(cacc_q) + (gcp_pkg::BoxChgW+1)'(chg_q);
	assign esum = (gcp_pkg::PotW+1)'(eacc_q) + (gcp_pkg::PotW+1)'(term);

	logic clash_now;
	assign clash_now = !mode && ({{(DW-THW){1'b0}}, thr_q} > root_q);

	// The root is complete once all of its steps have been taken.
	assign sts.sqrt_done = (scnt_q == SRW'(SQW / 2));
	assign sts.div_done  = (dcnt_q == DVW'(NUMW - 1));
	assign sts.need_div  = !clash_q && !clash_now && (root_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q     <= abs_dist(min_x, max_x, ax);
			dy_q     <= abs_dist(min_y, max_y, ay);
			dz_q     <= abs_dist(min_z, max_z, az);
			inside_q <= in_x && in_y && in_z;
			last_q   <= alast;
			chg_q    <= achg_known ? achg : '0;
			thr_q    <= THW'(arad_known ? arad : gcp_pkg::RadiusW'(MIN_RADIUS))
				+ THW'(CLASH_OFFSET) + THW'(probe);
		end
		if (cmd.sq_sum)
			sq_q <= SQW'(dx_q * dx_q) + SQW'(dy_q * dy_q) + SQW'(dz_q * dz_q);
		if (cmd.sqrt_init) begin
			rem_q  <= '0;
			root_q <= '0;
			scnt_q <= '0;
		end else if (cmd.sqrt_step && !sts.sqrt_done) begin
			if (shifted >= (SQW+2)'(trial)) begin
				rem_q  <= SQW'(shifted - (SQW+2)'(trial));
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= SQW'(shifted);
				root_q <= {root_q[DW-2:0], 1'b0};
			end
			scnt_q <= scnt_q + 1'b1;
		end
		if (cmd.div_init) begin
			neg_q  <= chg_q[gcp_pkg::ChargeW-1];
			quo_q  <= NUMW'(chg_q[gcp_pkg::ChargeW-1] ? -NUMW'(chg_q) : NUMW'(chg_q))
				<< COORD_FRAC_BITS;
			drem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (dshift >= {1'b0, root_q}) begin
				drem_q <= dshift - {1'b0, root_q};
				quo_q  <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				drem_q <= dshift;
				quo_q  <= {quo_q[NUMW-2:0], 1'b0};
			end
			if (!sts.div_done) dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.finish && last_q) begin
			out_chg   <= (inside_q) ? ((csum > (gcp_pkg::BoxChgW+1)'(ChgMax)) ? ChgMax :
				(csum < (gcp_pkg::BoxChgW+1)'(ChgMin)) ? ChgMin : gcp_pkg::BoxChgW'(csum))
				: cacc_q;
			out_clash <= clash_q || clash_now;
			out_pot   <= (clash_q || clash_now) ? PotMax :
				!sts.need_div ? eacc_q :
				(esum > (gcp_pkg::PotW+1)'(PotMax)) ? PotMax :
				(esum < (gcp_pkg::PotW+1)'(PotMin)) ? PotMin : gcp_pkg::PotW'(esum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cacc_q    <= '0;
			eacc_q    <= '0;
			clash_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.finish && last_q) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.finish) begin
				if (last_q) begin
					cacc_q    <= '0;
					eacc_q    <= '0;
					clash_q   <= 1'b0;
				end else begin
					if (inside_q)
						cacc_q <= (csum > (gcp_pkg::BoxChgW+1)'(ChgMax)) ? ChgMax :
							(csum < (gcp_pkg::BoxChgW+1)'(ChgMin)) ? ChgMin
							: gcp_pkg::BoxChgW'(csum);
					if (clash_now && !clash_q) clash_q <= 1'b1;
					else if (sts.need_div)
						eacc_q <= (esum > (gcp_pkg::PotW+1)'(PotMax)) ? PotMax :
							(esum < (gcp_pkg::PotW+1)'(PotMin)) ? PotMin
							: gcp_pkg::PotW'(esum);
				end
			end
		end
	end

	`GCP_ASSERT_IMP(a_clash_pot, clk, arst_n, out_valid && out_clash, out_pot == PotMax,
		"clash result must carry the largest potential")
	`GCP_ASSERT_IMP(a_no_div_on_clash, clk, arst_n, cmd.div_step, !clash_q,
		"division started after a clash")
	`GCP_ASSERT_NEXT(a_clear_after_last, clk, arst_n, cmd.finish && last_q,
		cacc_q == '0 && !clash_q, "sums not cleared after the last atom")
endmodule

// ----- sv/grid_cell_coulomb_potential.sv -----
// ----------------------------------------------------------------------------
// grid_cell_coulomb_potential
// Charge and Coulomb potential of one grid cell from a stream of atoms.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  atom    | sink      | atom_x/y/z, atom_charge, charge_known, atom_radius,
//          |           | radius_known, last_atom
//  result  | source    | box_charge, potential, clash
//  cfg     | write     | cfg_we, cfg_index, cfg_data
//
// Each atom passes through load, square sum, root start, the root steps and
// a step to see the root complete, then a divide start and the divide steps
// when a potential term is added, and a final step. The bit-serial square root
// and the bit-serial divider are iterative; one atom is in flight at a time.
// Reset clears the sums, the clash flag, the configuration registers and the result valid.
// A result waiting to be taken only stalls the sequencer at its final step
// of the next atom; the next atom is still accepted and worked on.
// ----------------------------------------------------------------------------
module grid_cell_coulomb_potential #(
	parameter int MIN_RADIUS      = gcp_pkg::MinRadiusDef,
	parameter int CLASH_OFFSET    = gcp_pkg::ClashOffsetDef,
	parameter int COORD_FRAC_BITS = gcp_pkg::CoordFracDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gcp_stream_if.sink                     atom,
	gcp_stream_if.source                   result,
	input  logic                           cfg_we,
	input  logic [gcp_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [gcp_pkg::CfgDataW-1:0]   cfg_data
);
	// Configuration registers; every index in range names a register.
	logic signed [gcp_pkg::CoordW-1:0] min_x_q, min_y_q, min_z_q;
	logic signed [gcp_pkg::CoordW-1:0] max_x_q, max_y_q, max_z_q;
	logic [gcp_pkg::RadiusW-1:0]       probe_q;
	logic                              mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0; min_y_q <= '0; min_z_q <= '0;
			max_x_q <= '0; max_y_q <= '0; max_z_q <= '0;
			probe_q <= '0; mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcp_pkg::RegMinX:  min_x_q <= cfg_data;
				gcp_pkg::RegMinY:  min_y_q <= cfg_data;
				gcp_pkg::RegMinZ:  min_z_q <= cfg_data;
				gcp_pkg::RegMaxX:  max_x_q <= cfg_data;
				gcp_pkg::RegMaxY:  max_y_q <= cfg_data;
				gcp_pkg::RegMaxZ:  max_z_q <= cfg_data;
				gcp_pkg::RegProbe: probe_q <= cfg_data[gcp_pkg::RadiusW-1:0];
				gcp_pkg::RegMode:  mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gcp_pkg::gcp_cmd_t cmd;
	gcp_pkg::gcp_sts_t sts;

	// The sequencer waits at its final step only while an older result is unread.
	gcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (atom.valid),
		.in_ready (atom.ready),
		.out_busy (result.valid && !result.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcp_datapath #(
		.MIN_RADIUS      (MIN_RADIUS),
		.CLASH_OFFSET    (CLASH_OFFSET),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.min_x      (min_x_q), .min_y (min_y_q), .min_z (min_z_q),
		.max_x      (max_x_q), .max_y (max_y_q), .max_z (max_z_q),
		.probe      (probe_q),
		.mode       (mode_q),
		.ax         (atom.data.atom_x),
		.ay         (atom.data.atom_y),
		.az         (atom.data.atom_z),
		.achg       (atom.data.atom_charge),
		.achg_known (atom.data.charge_known),
		.arad       (atom.data.atom_radius),
		.arad_known (atom.data.radius_known),
		.alast      (atom.data.last_atom),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_chg    (result.data.box_charge),
		.out_pot    (result.data.potential),
		.out_clash  (result.data.clash)
	);
endmodule
